[rtl/lzss_pkg.sv]
package lzss_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAG,
        PH_TOKEN,
        PH_LEN,
        PH_DIST,
        PH_COPY_RD,
        PH_COPY_WR
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_DIST,
        ERR_LEN,
        ERR_LEB
    } err_t;

    localparam int unsigned MAX_MATCH = 258;
    localparam int unsigned LEN_BASE = 3;
    localparam logic [31:0] LEN_LIMIT = 32'(MAX_MATCH - LEN_BASE);
    localparam logic [5:0]  LEB_SHIFT_LIMIT = 6'd35;
    localparam logic [2:0]  LANE_LAST = 3'd7;
    localparam logic [3:0]  HDR_BYTES = 4'd8;

endpackage

[rtl/lzss_hist_ram.sv]
module lzss_hist_ram #(
    parameter int unsigned DEPTH  = 32768,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/lzss_leb128_stream_decoder.sv]
// channel | ports                                                   | direction
// s_      | s_valid s_ready s_in_byte                               | compressed bytes in
// m_      | m_valid m_ready m_out_bytes m_out_count m_run_last      | decoded words out
//         | m_stream_done m_error_code                              |
// header, flag, literal and length/distance bytes each take one input handshake
// a match copy then runs each byte through the single history RAM port pair
// (read in PH_COPY_RD, then write back in PH_COPY_WR), holding s_ready low until the copy ends
// output register stalls (m_ready low) pause parsing; the copy sequencer runs on until it must emit a word
// aresetn is synchronous; history RAM is not cleared, no clearing pass
module lzss_leb128_stream_decoder #(
    parameter int unsigned WINDOW_BYTES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_bytes,
    output logic [3:0]  m_out_count,
    output logic        m_run_last,
    output logic        m_stream_done,
    output logic [1:0]  m_error_code
);
    import lzss_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW_BYTES);
    localparam logic [AW:0]   WIN    = (AW+1)'(WINDOW_BYTES);
    localparam logic [31:0]   WIN32  = 32'(WINDOW_BYTES);
    localparam logic [AW-1:0] WLAST  = AW'(WINDOW_BYTES - 1);

    phase_t       phase_reg, phase_next;
    logic [63:0]  target_reg, target_next;
    logic [3:0]   hcnt_reg, hcnt_next;
    logic [63:0]  produced_reg, produced_next;
    logic [7:0]   flag_bits_reg, flag_bits_next;
    logic [3:0]   flags_rem_reg, flags_rem_next;
    logic [31:0]  leb_acc_reg, leb_acc_next;
    logic [5:0]   leb_shift_reg, leb_shift_next;
    logic [8:0]   mlen_reg, mlen_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [8:0]   copy_rem_reg, copy_rem_next;
    logic [63:0]  word_reg, word_next;
    logic [2:0]   wcnt_reg, wcnt_next;

    logic         m_valid_reg;
    logic [63:0]  obytes_reg;
    logic [3:0]   ocount_reg;
    logic         olast_reg, odone_reg;
    err_t         oerr_reg;

    logic         out_load;
    logic [63:0]  obytes_n;
    logic [3:0]   ocount_n;
    logic         olast_n, odone_n;
    err_t         oerr_n;

    logic         out_free, acc, parse_ph;
    logic [31:0]  base_acc, leb_ext, leb_acc_n;
    logic [5:0]   base_shift, leb_shift_n;
    logic         leb_over;
    logic [63:0]  produced_inc, room;
    logic         fin;
    logic [8:0]   copy_n;
    logic [AW:0]  copy_dist, wp_wide;
    logic [AW-1:0] wp_inc, rp_inc, rp_start;
    logic [3:0]   flags_dec;

    logic         put_en, put_last;
    logic [7:0]   put_byte;
    logic [63:0]  word_acc;

    logic         ram_we, ram_re;
    logic [7:0]   ram_rdata;

    lzss_hist_ram #(
        .DEPTH  (WINDOW_BYTES),
        .ADDR_W (AW)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (put_byte),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign parse_ph = phase_reg inside {PH_HEADER, PH_FLAG, PH_TOKEN, PH_LEN, PH_DIST};
    assign s_ready  = parse_ph && out_free;
    assign acc      = s_valid && s_ready;

    // a match token's first byte is already the first length byte
    assign base_acc    = (phase_reg == PH_TOKEN) ? 32'd0 : leb_acc_reg;
    assign base_shift  = (phase_reg == PH_TOKEN) ? 6'd0 : leb_shift_reg;
    assign leb_ext     = {25'd0, s_in_byte[6:0]} << base_shift[4:0];
    assign leb_acc_n   = (base_shift < 6'd32) ? (base_acc | leb_ext) : base_acc;
    assign leb_shift_n = base_shift + 6'd7;
    assign leb_over    = s_in_byte[7] && (leb_shift_n >= LEB_SHIFT_LIMIT);

    assign produced_inc = produced_reg + 64'd1;
    assign fin          = produced_inc >= target_reg;
    assign room         = target_reg - produced_reg;
    assign copy_n       = (room < {55'd0, mlen_reg}) ? room[8:0] : mlen_reg;

    assign copy_dist = {1'b0, leb_acc_n[AW-1:0]} + (AW+1)'(1);
    assign wp_wide   = {1'b0, wp_reg};
    assign rp_start  = (wp_wide >= copy_dist) ? AW'(wp_wide - copy_dist)
                                              : AW'(wp_wide + WIN - copy_dist);
    assign wp_inc   = (wp_reg == WLAST) ? '0 : wp_reg + AW'(1);
    assign rp_inc   = (rp_reg == WLAST) ? '0 : rp_reg + AW'(1);
    assign flags_dec = (flags_rem_reg != 4'd0) ? flags_rem_reg - 4'd1 : flags_rem_reg;

    assign word_acc = word_reg | ({56'd0, put_byte} << {wcnt_reg, 3'b000});

    always_comb begin
        phase_next     = phase_reg;
        target_next    = target_reg;
        hcnt_next      = hcnt_reg;
        produced_next  = produced_reg;
        flag_bits_next = flag_bits_reg;
        flags_rem_next = flags_rem_reg;
        leb_acc_next   = leb_acc_reg;
        leb_shift_next = leb_shift_reg;
        mlen_next      = mlen_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        copy_rem_next  = copy_rem_reg;
        word_next      = word_reg;
        wcnt_next      = wcnt_reg;
        put_en         = 1'b0;
        put_last       = 1'b0;
        put_byte       = s_in_byte;
        ram_re         = 1'b0;
        out_load       = 1'b0;
        obytes_n       = '0;
        ocount_n       = '0;
        olast_n        = 1'b1;
        odone_n        = 1'b0;
        oerr_n         = ERR_NONE;

        case (phase_reg)
            PH_HEADER: begin
                if (acc) begin
                    target_next[{hcnt_reg[2:0], 3'b000} +: 8] = s_in_byte;
                    hcnt_next = hcnt_reg + 4'd1;
                    if (hcnt_next >= HDR_BYTES) begin
                        produced_next  = '0;
                        flags_rem_next = '0;
                        flag_bits_next = '0;
                        leb_acc_next   = '0;
                        leb_shift_next = '0;
                        if (target_next == 64'd0) begin
                            // empty stream
                            out_load    = 1'b1;
                            odone_n     = 1'b1;
                            hcnt_next   = '0;
                            target_next = '0;
                        end else begin
                            phase_next = PH_FLAG;
                        end
                    end
                end
            end
            PH_FLAG: begin
                if (acc) begin
                    flag_bits_next = s_in_byte;
                    flags_rem_next = 4'd8;
                    phase_next     = PH_TOKEN;
                end
            end
            PH_TOKEN, PH_LEN: begin
                if (acc && phase_reg == PH_TOKEN) begin
                    flag_bits_next = {flag_bits_reg[6:0], 1'b0};
                    flags_rem_next = flags_dec;
                end
                if (acc && phase_reg == PH_TOKEN && !flag_bits_reg[7]) begin
                    put_en        = 1'b1;
                    put_last      = 1'b1;
                    produced_next = produced_inc;
                    wp_next       = wp_inc;
                    if (fin) begin
                        phase_next  = PH_HEADER;
                        hcnt_next   = '0;
                        target_next = '0;
                    end else begin
                        phase_next = (flags_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end
                end else if (acc) begin
                    leb_acc_next   = leb_acc_n;
                    leb_shift_next = leb_shift_n;
                    phase_next     = PH_LEN;
                    if (leb_over || (!s_in_byte[7] && leb_acc_n > LEN_LIMIT)) begin
                        out_load       = 1'b1;
                        oerr_n         = leb_over ? ERR_LEB : ERR_LEN;
                        leb_acc_next   = '0;
                        leb_shift_next = '0;
                        phase_next     = PH_HEADER;
                        hcnt_next      = '0;
                        target_next    = '0;
                    end else if (!s_in_byte[7]) begin
                        mlen_next      = leb_acc_n[8:0] + 9'(LEN_BASE);
                        leb_acc_next   = '0;
                        leb_shift_next = '0;
                        phase_next     = PH_DIST;
                    end
                end
            end
            PH_DIST: begin
                if (acc) begin
                    leb_acc_next   = leb_acc_n;
                    leb_shift_next = leb_shift_n;
                    if (leb_over || (!s_in_byte[7] &&
                        (leb_acc_n >= WIN32 || {32'd0, leb_acc_n} >= produced_reg))) begin
                        out_load       = 1'b1;
                        oerr_n         = leb_over ? ERR_LEB : ERR_DIST;
                        leb_acc_next   = '0;
                        leb_shift_next = '0;
                        phase_next     = PH_HEADER;
                        hcnt_next      = '0;
                        target_next    = '0;
                    end else if (!s_in_byte[7]) begin
                        leb_acc_next   = '0;
                        leb_shift_next = '0;
                        rp_next        = rp_start;
                        copy_rem_next  = copy_n;
                        phase_next     = PH_COPY_RD;
                    end
                end
            end
            PH_COPY_RD: begin
                ram_re     = 1'b1;
                phase_next = PH_COPY_WR;
            end
            PH_COPY_WR: begin
                put_byte = ram_rdata;
                put_last = (copy_rem_reg == 9'd1);
                if (out_free || (wcnt_reg != LANE_LAST && !put_last)) begin
                    put_en        = 1'b1;
                    produced_next = produced_inc;
                    wp_next       = wp_inc;
                    rp_next       = rp_inc;
                    copy_rem_next = copy_rem_reg - 9'd1;
                    if (!put_last) begin
                        phase_next = PH_COPY_RD;
                    end else if (fin) begin
                        phase_next  = PH_HEADER;
                        hcnt_next   = '0;
                        target_next = '0;
                    end else begin
                        phase_next = (flags_rem_reg == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end
                end
            end
            default: begin
                phase_next  = PH_HEADER;
                hcnt_next   = '0;
                target_next = '0;
            end
        endcase

        if (put_en) begin
            if (wcnt_reg == LANE_LAST || put_last) begin
                out_load  = 1'b1;
                obytes_n  = word_acc;
                ocount_n  = {1'b0, wcnt_reg} + 4'd1;
                olast_n   = put_last;
                odone_n   = put_last && fin;
                word_next = '0;
                wcnt_next = '0;
            end else begin
                word_next = word_acc;
                wcnt_next = wcnt_reg + 3'd1;
            end
        end
    end

    assign ram_we = put_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            target_reg    <= '0;
            hcnt_reg      <= '0;
            produced_reg  <= '0;
            flag_bits_reg <= '0;
            flags_rem_reg <= '0;
            leb_acc_reg   <= '0;
            leb_shift_reg <= '0;
            mlen_reg      <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            copy_rem_reg  <= '0;
            word_reg      <= '0;
            wcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            hcnt_reg      <= hcnt_next;
            produced_reg  <= produced_next;
            flag_bits_reg <= flag_bits_next;
            flags_rem_reg <= flags_rem_next;
            leb_acc_reg   <= leb_acc_next;
            leb_shift_reg <= leb_shift_next;
            mlen_reg      <= mlen_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            copy_rem_reg  <= copy_rem_next;
            word_reg      <= word_next;
            wcnt_reg      <= wcnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            obytes_reg <= obytes_n;
            ocount_reg <= ocount_n;
            olast_reg  <= olast_n;
            odone_reg  <= odone_n;
            oerr_reg   <= oerr_n;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_bytes   = obytes_reg;
    assign m_out_count   = ocount_reg;
    assign m_run_last    = olast_reg;
    assign m_stream_done = odone_reg;
    assign m_error_code  = oerr_reg;
endmodule

[rtl/lzss_chk.sv]
module lzss_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_in_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_out_bytes,
    input logic [3:0]  m_out_count,
    input logic        m_run_last,
    input logic        m_stream_done,
    input logic [1:0]  m_error_code
);
    import lzss_pkg::*;

    // a held word keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_bytes) && $stable(m_out_count))
        else $error("output word changed while stalled");

    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_NONE |-> m_out_count == 4'd0 && m_run_last
            && !m_stream_done)
        else $error("error word carries data");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_done |-> m_run_last)
        else $error("stream done on a non-final word");

    // only the final word of a run may be partial
    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |-> m_out_count == 4'd8)
        else $error("partial word before end of run");

    // input taken while a non-final word is held is flagged only if that word is partial and unchanged
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |-> !(s_valid && s_ready) || !$stable(m_out_count)
            || m_out_count == 4'd8)
        else $error("input taken mid run");
endmodule

bind lzss_leb128_stream_decoder lzss_chk u_lzss_chk (.*);
